// File: hdl/cl3d_pkg.sv
// Shared types and constants for the CRLF line parser with three decimal values.
package cl3d_pkg;

    // Character codes that the parser recognises.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] DEC_RADIX = 8'd10;

    // The line length limit after reset.
    localparam logic [7:0] MAX_LEN_RESET = 8'd255;

    // Result status codes.
    localparam logic STATUS_LINE     = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    // Depth of the queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified character word as it travels through the queue.
    typedef struct packed {
        logic       is_dig;
        logic       is_sep;
        logic       is_cr;
        logic       is_lf;
        logic [3:0] digit;
    } t_word;

endpackage

// File: hdl/cl3d_front.sv
// Front part: classifies each received byte into a compact character word.
module cl3d_front (
    input  logic [7:0]     i_rx_byte,
    output cl3d_pkg::t_word o_word
);

    logic w_is_dig;
    logic w_is_cr;
    logic w_is_lf;
    logic w_is_sp;

    // Decode the character classes the parser needs.
    always_comb begin
        w_is_dig = (i_rx_byte >= cl3d_pkg::CH_ZERO) && (i_rx_byte <= cl3d_pkg::CH_NINE);
        w_is_cr  = (i_rx_byte == cl3d_pkg::CH_CR);
        w_is_lf  = (i_rx_byte == cl3d_pkg::CH_LF);
        w_is_sp  = (i_rx_byte == cl3d_pkg::CH_SP);
    end

    // Pack the word; the digit value is zero for anything but a digit.
    always_comb begin
        o_word.is_dig = w_is_dig;
        o_word.is_sep = w_is_sp || w_is_cr || w_is_lf;
        o_word.is_cr  = w_is_cr;
        o_word.is_lf  = w_is_lf;
        o_word.digit  = w_is_dig ? 4'(i_rx_byte - cl3d_pkg::CH_ZERO) : 4'd0;
    end

endmodule

// File: hdl/cl3d_queue.sv
// Short queue of classified words between the front and back parts.
module cl3d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cl3d_pkg::t_word i_word,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cl3d_pkg::t_word o_word
);

    localparam logic [cl3d_pkg::QPTR_W-1:0] PTR_LAST = cl3d_pkg::QPTR_W'(cl3d_pkg::QDEPTH - 1);
    localparam logic [cl3d_pkg::QCNT_W-1:0] CNT_FULL = cl3d_pkg::QCNT_W'(cl3d_pkg::QDEPTH);

    cl3d_pkg::t_word                 r_mem [cl3d_pkg::QDEPTH];
    logic [cl3d_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [cl3d_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [cl3d_pkg::QCNT_W-1:0]     r_count;
    logic [cl3d_pkg::QPTR_W-1:0]     n_wr_ptr;
    logic [cl3d_pkg::QPTR_W-1:0]     n_rd_ptr;
    logic [cl3d_pkg::QCNT_W-1:0]     n_count;
    logic                            w_do_push;
    logic                            w_do_pop;

    assign o_full    = (r_count == CNT_FULL);
    assign o_valid   = (r_count != '0);
    assign o_word    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_do_push, w_do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Word storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

// File: hdl/cl3d_back.sv
// Back part: line state, decimal accumulation and the registered result.
module cl3d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_word_valid,
    input  cl3d_pkg::t_word i_word,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_status,
    output logic [7:0]      o_value_a,
    output logic [7:0]      o_value_b,
    output logic [7:0]      o_value_c
);

    // Parse phase codes.
    localparam logic [2:0] PH_SKIP_A = 3'd0;
    localparam logic [2:0] PH_IN_A   = 3'd1;
    localparam logic [2:0] PH_SKIP_B = 3'd2;
    localparam logic [2:0] PH_IN_B   = 3'd3;
    localparam logic [2:0] PH_SKIP_C = 3'd4;
    localparam logic [2:0] PH_IN_C   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    logic [7:0] r_max_len;
    logic [2:0] r_phase;
    logic [7:0] r_acc_a;
    logic [7:0] r_acc_b;
    logic [7:0] r_acc_c;
    logic [7:0] r_line_count;
    logic       r_last_cr;
    logic       r_out_valid;
    logic       r_status;
    logic [7:0] r_val_a;
    logic [7:0] r_val_b;
    logic [7:0] r_val_c;

    logic [2:0] n_phase;
    logic [7:0] n_acc_a;
    logic [7:0] n_acc_b;
    logic [7:0] n_acc_c;
    logic [7:0] n_line_count;
    logic       n_last_cr;

    logic       w_overflow;
    logic       w_pair;
    logic       w_emit;
    logic [7:0] w_mac_in;
    logic [7:0] w_mac_out;

    // A word is taken whenever the result register is free or being emptied.
    assign o_pop      = i_word_valid && (!r_out_valid || i_ready);
    assign w_overflow = (r_line_count >= r_max_len);
    assign w_pair     = r_last_cr && i_word.is_lf;
    assign w_emit     = w_overflow || w_pair;

    // The one accumulator that the current phase extends by a digit.
    always_comb begin
        case (r_phase)
            PH_IN_A: w_mac_in = r_acc_a;
            PH_IN_B: w_mac_in = r_acc_b;
            PH_IN_C: w_mac_in = r_acc_c;
            default: w_mac_in = 8'd0;
        endcase
        w_mac_out = 8'(w_mac_in * cl3d_pkg::DEC_RADIX + {4'd0, i_word.digit});
    end

    // Next line state for the word at the head of the queue.
    always_comb begin
        n_phase      = r_phase;
        n_acc_a      = r_acc_a;
        n_acc_b      = r_acc_b;
        n_acc_c      = r_acc_c;
        n_line_count = r_line_count + 1'b1;
        n_last_cr    = i_word.is_cr;
        case (r_phase)
            PH_SKIP_A, PH_SKIP_B, PH_SKIP_C: begin
                if (i_word.is_dig) begin
                    if (r_phase == PH_SKIP_A) begin
                        n_acc_a = {4'd0, i_word.digit};
                    end else if (r_phase == PH_SKIP_B) begin
                        n_acc_b = {4'd0, i_word.digit};
                    end else begin
                        n_acc_c = {4'd0, i_word.digit};
                    end
                    n_phase = r_phase + 1'b1;
                end else if (!i_word.is_sep) begin
                    n_phase = PH_DONE;
                end
            end
            PH_IN_A, PH_IN_B, PH_IN_C: begin
                if (i_word.is_dig) begin
                    if (r_phase == PH_IN_A) begin
                        n_acc_a = w_mac_out;
                    end else if (r_phase == PH_IN_B) begin
                        n_acc_b = w_mac_out;
                    end else begin
                        n_acc_c = w_mac_out;
                    end
                end else if (i_word.is_sep && (r_phase != PH_IN_C)) begin
                    n_phase = r_phase + 1'b1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // Line state and the configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= cl3d_pkg::MAX_LEN_RESET;
            r_phase      <= PH_SKIP_A;
            r_acc_a      <= 8'd0;
            r_acc_b      <= 8'd0;
            r_acc_c      <= 8'd0;
            r_line_count <= 8'd0;
            r_last_cr    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (o_pop) begin
                if (w_emit) begin
                    r_phase      <= PH_SKIP_A;
                    r_acc_a      <= 8'd0;
                    r_acc_b      <= 8'd0;
                    r_acc_c      <= 8'd0;
                    r_line_count <= 8'd0;
                    r_last_cr    <= 1'b0;
                end else begin
                    r_phase      <= n_phase;
                    r_acc_a      <= n_acc_a;
                    r_acc_b      <= n_acc_b;
                    r_acc_c      <= n_acc_c;
                    r_line_count <= n_line_count;
                    r_last_cr    <= n_last_cr;
                end
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; overflow results carry zero values.
    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            if (w_overflow) begin
                r_status <= cl3d_pkg::STATUS_OVERFLOW;
                r_val_a  <= 8'd0;
                r_val_b  <= 8'd0;
                r_val_c  <= 8'd0;
            end else begin
                r_status <= cl3d_pkg::STATUS_LINE;
                r_val_a  <= n_acc_a;
                r_val_b  <= n_acc_b;
                r_val_c  <= n_acc_c;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_value_a = r_val_a;
    assign o_value_b = r_val_b;
    assign o_value_c = r_val_c;

endmodule

// File: hdl/crlf_line_three_decimal_parser.sv
// Top level of the CRLF line parser that extracts three decimal values per line.
//
// Input channel: one received byte per word on i_rx_byte, moved by i_valid/o_ready.
// Output channel: one result word per completed or overflowed line on o_status and
// o_value_a..o_value_c, moved by o_valid/i_ready. A CR directly followed by LF ends
// a line with status 0 and the three values modulo 256; reaching the length limit
// drops the byte and gives status 1 with zero values.
// Configuration: i_cfg_we writes i_cfg_data into the line length limit (255 after
// reset); the user must write it only while the block is idle; the block does not enforce this.
// Throughput: one byte per cycle while the back part is not stalled by a waiting
// result. With nothing ahead of it in the queue, the byte that causes a result is
// written into the four-word queue at acceptance, and the back part then moves
// its result into the result register, where o_valid rises.
// Reset: synchronous and active low; it empties the queue, clears the line state
// and the result valid flag and restores the limit. o_ready is high straight after.
// Stalls: while a result waits with i_ready low it is held and the back part takes
// no further bytes; the queue absorbs up to four more before o_ready falls.
module crlf_line_three_decimal_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_status,
    output logic [7:0] o_value_a,
    output logic [7:0] o_value_b,
    output logic [7:0] o_value_c
);

    cl3d_pkg::t_word w_front_word;
    cl3d_pkg::t_word w_queue_word;
    logic            w_queue_full;
    logic            w_queue_valid;
    logic            w_pop;

    assign o_ready = !w_queue_full;

    // Classify incoming bytes.
    cl3d_front u_front (
        .i_rx_byte (i_rx_byte),
        .o_word    (w_front_word)
    );

    // Decouple the input from the parsing back part.
    cl3d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_word  (w_front_word),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_word  (w_queue_word)
    );

    // Parse the words and produce results.
    cl3d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_word_valid (w_queue_valid),
        .i_word       (w_queue_word),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_value_a    (o_value_a),
        .o_value_b    (o_value_b),
        .o_value_c    (o_value_c)
    );

endmodule

// File: hdl/cl3d_checker.sv
// Port-level checker for the CRLF line parser and its bind to the top level.
module cl3d_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_ready,
    input  logic       o_valid,
    input  logic       i_ready,
    input  logic       o_status,
    input  logic [7:0] o_value_a,
    input  logic [7:0] o_value_b,
    input  logic [7:0] o_value_c
);

    // A stalled result word holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_value_a)
            && $stable(o_value_b) && $stable(o_value_c)))
        else $error("Result word changed while stalled.");

    // A result is only withdrawn once it has been taken.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(i_ready))
        else $error("Result word dropped before it was taken.");

    // Reset leaves no result pending and the input open.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_ready))
        else $error("Block not empty and ready after reset.");

    // Overflow results carry zero values.
    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> ((o_value_a == 8'd0) && (o_value_b == 8'd0)
            && (o_value_c == 8'd0)))
        else $error("Overflow result carries non-zero values.");

endmodule

bind crlf_line_three_decimal_parser cl3d_checker u_cl3d_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_status   (o_status),
    .o_value_a  (o_value_a),
    .o_value_b  (o_value_b),
    .o_value_c  (o_value_c)
);
